[sv/rlmp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the route list message parser.
// No dependencies; imported by every other file of the block.
package rlmp_pkg;

  // Record type bytes.
  localparam logic [7:0] TYPE_V4 = 8'h01;
  localparam logic [7:0] TYPE_V6 = 8'h02;

  // Address bytes per record type.
  localparam logic [4:0] V4_BYTES      = 5'd4;
  localparam logic [4:0] V6_BYTES      = 5'd16;
  localparam logic [4:0] VERSION_BYTES = 5'd4;

  // Result kinds.
  localparam logic [1:0] KIND_VERSION = 2'd0;
  localparam logic [1:0] KIND_ROUTE   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Address families.
  localparam logic FAM_V4 = 1'b0;
  localparam logic FAM_V6 = 1'b1;

  // End status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_TRAIL   = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } rlmp_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic        address_family;
    logic [7:0]  prefix_bits;
    logic [63:0] address_upper;
    logic [63:0] address_lower;
    logic [2:0]  status;
    logic        is_last;
  } rlmp_out_t;

  // Results raised by one byte: at most two, the second always the end status.
  typedef struct packed {
    logic [1:0] cnt;
    rlmp_out_t  res0;
    rlmp_out_t  res1;
  } rlmp_emit_t;

endpackage

[sv/rlmp_parse.sv]
`timescale 1ns / 1ps
// Message state and per-byte decode for the route list message parser.
// Depends on rlmp_pkg.
module rlmp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rlmp_pkg::rlmp_in_t  item,
  output rlmp_pkg::rlmp_emit_t emit
);
  import rlmp_pkg::*;

  typedef enum logic [3:0] {
    PH_VERSION = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_PREFIX  = 4'b0100,
    PH_ADDR    = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [63:0] sh_hi_r, sh_hi_nxt;
  logic [63:0] sh_lo_r, sh_lo_nxt;
  logic        disc_r, disc_nxt;

  logic [63:0] shifted_hi, shifted_lo;
  logic [4:0]  cnt_inc, need;
  logic        known_type;
  logic        emit_main, emit_end;
  logic [2:0]  end_status;
  rlmp_out_t   main_res, end_res;

  assign shifted_lo = {sh_lo_r[55:0], item.data_byte};
  assign shifted_hi = {sh_hi_r[55:0], sh_lo_r[63:56]};
  assign cnt_inc    = cnt_r + 5'd1;
  assign known_type = (type_r == TYPE_V4) || (type_r == TYPE_V6);
  assign need       = (type_r == TYPE_V4) ? V4_BYTES : V6_BYTES;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    type_nxt   = type_r;
    prefix_nxt = prefix_r;
    sh_hi_nxt  = sh_hi_r;
    sh_lo_nxt  = sh_lo_r;
    disc_nxt   = disc_r;
    emit_main  = 1'b0;
    emit_end   = 1'b0;
    end_status = ST_OK;
    main_res   = '0;

    if (disc_r) begin
      // skip to the end mark
      emit_end   = item.end_of_message;
      end_status = ST_UNKNOWN;
    end else begin
      unique case (phase_r)
        PH_VERSION: begin
          sh_hi_nxt = shifted_hi;
          sh_lo_nxt = shifted_lo;
          cnt_nxt   = cnt_inc;
          if (cnt_inc >= VERSION_BYTES) begin
            emit_main                 = 1'b1;
            main_res.record_kind      = KIND_VERSION;
            main_res.address_lower    = {32'd0, shifted_lo[31:0]};
            phase_nxt                 = PH_TYPE;
            cnt_nxt                   = '0;
            emit_end                  = item.end_of_message;
            end_status                = ST_OK;
          end else begin
            emit_end   = item.end_of_message;
            end_status = ST_SHORT;
          end
        end
        PH_TYPE: begin
          type_nxt   = item.data_byte;
          phase_nxt  = PH_PREFIX;
          emit_end   = item.end_of_message;
          end_status = ST_TRAIL;
        end
        PH_PREFIX: begin
          prefix_nxt = item.data_byte;
          phase_nxt  = PH_ADDR;
          cnt_nxt    = '0;
          sh_hi_nxt  = '0;
          sh_lo_nxt  = '0;
          emit_end   = item.end_of_message;
          end_status = ST_TRAIL;
        end
        PH_ADDR: begin
          if (!known_type) begin
            emit_end   = item.end_of_message;
            end_status = ST_UNKNOWN;
            disc_nxt   = !item.end_of_message;
          end else begin
            sh_hi_nxt = shifted_hi;
            sh_lo_nxt = shifted_lo;
            cnt_nxt   = cnt_inc;
            if (cnt_inc >= need) begin
              emit_main            = 1'b1;
              main_res.record_kind = KIND_ROUTE;
              main_res.prefix_bits = prefix_r;
              if (type_r == TYPE_V4) begin
                main_res.address_family = FAM_V4;
                main_res.address_lower  = {32'd0, shifted_lo[31:0]};
              end else begin
                main_res.address_family = FAM_V6;
                main_res.address_upper  = shifted_hi;
                main_res.address_lower  = shifted_lo;
              end
              phase_nxt  = PH_TYPE;
              cnt_nxt    = '0;
              emit_end   = item.end_of_message;
              end_status = ST_OK;
            end else begin
              emit_end   = item.end_of_message;
              end_status = ST_TRUNC;
            end
          end
        end
        default: begin
          phase_nxt = PH_VERSION;
          cnt_nxt   = '0;
          type_nxt  = '0;
          prefix_nxt = '0;
          sh_hi_nxt = '0;
          sh_lo_nxt = '0;
          disc_nxt  = 1'b0;
        end
      endcase
    end

    // every end mark returns the message state to reset
    if (emit_end) begin
      phase_nxt  = PH_VERSION;
      cnt_nxt    = '0;
      type_nxt   = '0;
      prefix_nxt = '0;
      sh_hi_nxt  = '0;
      sh_lo_nxt  = '0;
      disc_nxt   = 1'b0;
    end
  end

  always_comb begin
    end_res             = '0;
    end_res.record_kind = KIND_END;
    end_res.status      = end_status;
    end_res.is_last     = 1'b1;
    emit.cnt  = {1'b0, emit_main} + {1'b0, emit_end};
    emit.res0 = emit_main ? main_res : end_res;
    emit.res1 = end_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VERSION;
      cnt_r    <= '0;
      type_r   <= '0;
      prefix_r <= '0;
      sh_hi_r  <= '0;
      sh_lo_r  <= '0;
      disc_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      type_r   <= type_nxt;
      prefix_r <= prefix_nxt;
      sh_hi_r  <= sh_hi_nxt;
      sh_lo_r  <= sh_lo_nxt;
      disc_r   <= disc_nxt;
    end
  end

endmodule

[sv/rlmp_outq.sv]
`timescale 1ns / 1ps
// Two-entry result queue that drives the output channel.
// Depends on rlmp_pkg.
module rlmp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rlmp_pkg::rlmp_emit_t emit,
  output logic [1:0]           room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rlmp_pkg::rlmp_out_t  out_data
);
  import rlmp_pkg::*;

  logic [1:0] count_r, count_nxt;
  rlmp_out_t  q0_r, q0_nxt;
  rlmp_out_t  q1_r, q1_nxt;
  logic       pop;
  logic [1:0] left, add;
  rlmp_out_t  rem0;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = q0_r;
  assign pop       = out_valid && !out_stall;
  assign left      = count_r - {1'b0, pop};
  assign room      = 2'd2 - left;
  assign add       = push ? emit.cnt : 2'd0;
  assign rem0      = pop ? q1_r : q0_r;

  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    count_nxt = left + add;
    unique case (left)
      2'd0: begin
        if (add != 2'd0) q0_nxt = emit.res0;
        if (add == 2'd2) q1_nxt = emit.res1;
      end
      2'd1: begin
        q0_nxt = rem0;
        if (add != 2'd0) q1_nxt = emit.res0;
      end
      default: begin
        q0_nxt = q0_r;
        q1_nxt = q1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

[sv/route_list_message_parser_top.sv]
`timescale 1ns / 1ps
// Top level of the route list message parser: input register, parser, result queue.
// Depends on rlmp_pkg, rlmp_parse and rlmp_outq.

// Takes a route list message one payload byte per item, end_of_message set on
// the last byte, and gives one result item for the big-endian version word
// once its four bytes are in, one per complete IPv4 or IPv6 route record, and
// one end status item (is_last set) on the end mark. An unknown type byte drops
// the rest of the message after its prefix byte; the end status then reads
// unknown type, or trailing bytes if the end mark is on the type or prefix byte.
// Rate: one byte per cycle while the output does not stall. An accepted byte is
// held in the input register, decoded there, and its results are written into a
// two-entry queue whose head is offered. The end mark may raise two results at
// once; the queue holds both and drains one per cycle while unstalled, and the
// input side stalls only while the queue lacks room for the byte being decoded.
module route_list_message_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlmp_pkg::rlmp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rlmp_pkg::rlmp_out_t out_data
);
  import rlmp_pkg::*;

  logic       s1_valid_r;
  rlmp_in_t   s1_data_r;
  rlmp_emit_t emit;
  logic [1:0] room;
  logic       adv;

  // Decode the held byte only when the queue has room for all it raises.
  assign adv      = s1_valid_r && (emit.cnt <= room);
  // Hold the input register while its byte cannot advance.
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  rlmp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_data_r),
    .emit  (emit)
  );

  rlmp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .emit      (emit),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Only the end status closes a message.
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_last |-> out_data.record_kind == KIND_END)
    else $error("is_last on a result that is not an end status");

  // Two results from one byte: a data result first, then the end status.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit.cnt == 2'd2 |-> emit.res1.is_last && !emit.res0.is_last)
    else $error("result pair out of order");

  // An empty queue offers its full room.
  a_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> room == 2'd2)
    else $error("empty queue reports lost room");

  // A byte decoded with the end mark always raises the end status.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_data_r.end_of_message |-> emit.cnt != 2'd0)
    else $error("end mark raised no status");
`endif

endmodule

[tb/sv/route_list_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the route list message parser: predicts every result from
// the accepted bytes and compares it with what the parser hands out.
// Depends on rlmp_pkg.
module route_list_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rlmp_pkg::rlmp_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rlmp_pkg::rlmp_out_t out_data,
  output int unsigned         error_count,
  output int unsigned         results_outstanding
);
  import rlmp_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum logic [1:0] {
    AWAIT_VERSION,
    AWAIT_TYPE,
    AWAIT_PREFIX,
    AWAIT_ADDRESS
  } parse_step_t;

  parse_step_t  step;
  logic [4:0]   taken;
  logic [7:0]   rec_type;
  logic [7:0]   rec_prefix;
  logic [127:0] shift_reg;
  logic         skipping;

  rlmp_out_t    expected_results[$];
  int unsigned  mismatches;

  initial begin
    mismatches = 0;
    error_count = 0;
    results_outstanding = 0;
  end

  function automatic void clear_parse();
    step       = AWAIT_VERSION;
    taken      = '0;
    rec_type   = '0;
    rec_prefix = '0;
    shift_reg  = '0;
    skipping   = 1'b0;
  endfunction

  // Queue the end status and return to the start of a message.
  task automatic close_message(input logic [2:0] code);
    rlmp_out_t r;
    r = '0;
    r.record_kind = KIND_END;
    r.status      = code;
    r.is_last     = 1'b1;
    expected_results.push_back(r);
    clear_parse();
  endtask

  task automatic predict_byte(input rlmp_in_t item);
    rlmp_out_t  r;
    logic [4:0] need;
    r = '0;
    if (skipping) begin
      if (item.end_of_message) close_message(ST_UNKNOWN);
      return;
    end
    case (step)
      AWAIT_VERSION: begin
        shift_reg = {shift_reg[119:0], item.data_byte};
        taken = taken + 5'd1;
        if (taken >= VERSION_BYTES) begin
          r.record_kind   = KIND_VERSION;
          r.address_lower = {32'd0, shift_reg[31:0]};
          expected_results.push_back(r);
          step  = AWAIT_TYPE;
          taken = '0;
          if (item.end_of_message) close_message(ST_OK);
        end else if (item.end_of_message) begin
          close_message(ST_SHORT);
        end
      end
      AWAIT_TYPE: begin
        rec_type = item.data_byte;
        step = AWAIT_PREFIX;
        if (item.end_of_message) close_message(ST_TRAIL);
      end
      AWAIT_PREFIX: begin
        rec_prefix = item.data_byte;
        step       = AWAIT_ADDRESS;
        taken      = '0;
        shift_reg  = '0;
        if (item.end_of_message) close_message(ST_TRAIL);
      end
      AWAIT_ADDRESS: begin
        if (rec_type != TYPE_V4 && rec_type != TYPE_V6) begin
          if (item.end_of_message) close_message(ST_UNKNOWN);
          else skipping = 1'b1;
          return;
        end
        need = (rec_type == TYPE_V4) ? V4_BYTES : V6_BYTES;
        shift_reg = {shift_reg[119:0], item.data_byte};
        taken = taken + 5'd1;
        if (taken >= need) begin
          r.record_kind = KIND_ROUTE;
          r.prefix_bits = rec_prefix;
          if (rec_type == TYPE_V4) begin
            r.address_family = FAM_V4;
            r.address_lower  = {32'd0, shift_reg[31:0]};
          end else begin
            r.address_family = FAM_V6;
            r.address_upper  = shift_reg[127:64];
            r.address_lower  = shift_reg[63:0];
          end
          expected_results.push_back(r);
          step  = AWAIT_TYPE;
          taken = '0;
          if (item.end_of_message) close_message(ST_OK);
        end else if (item.end_of_message) begin
          close_message(ST_TRUNC);
        end
      end
      default: clear_parse();
    endcase
  endtask

  always @(posedge clk) begin
    rlmp_out_t want;
    if (!rst_n) begin
      clear_parse();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result kind %0d fam %0d prefix %02h up %016h low %016h",
                     $time, out_data.record_kind, out_data.address_family,
                     out_data.prefix_bits, out_data.address_upper, out_data.address_lower,
                     "  status %0d last %0d", out_data.status, out_data.is_last);
        end else begin
          want = expected_results.pop_front();
          if (out_data.record_kind    !== want.record_kind    ||
              out_data.address_family !== want.address_family ||
              out_data.prefix_bits    !== want.prefix_bits    ||
              out_data.address_upper  !== want.address_upper  ||
              out_data.address_lower  !== want.address_lower  ||
              out_data.status         !== want.status         ||
              out_data.is_last        !== want.is_last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mismatch, expected kind %0d fam %0d prefix %02h up %016h low %016h",
                       $time, want.record_kind, want.address_family, want.prefix_bits,
                       want.address_upper, want.address_lower,
                       " status %0d last %0d", want.status, want.is_last);
              $display("%0t:           got kind %0d fam %0d prefix %02h up %016h low %016h",
                       $time, out_data.record_kind, out_data.address_family,
                       out_data.prefix_bits, out_data.address_upper, out_data.address_lower,
                       " status %0d last %0d", out_data.status, out_data.is_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(in_data);
    end
    error_count         <= mismatches;
    results_outstanding <= expected_results.size();
  end

endmodule

[tb/sv/route_list_message_parser_top_test.sv]
`timescale 1ns / 1ps
// Test top for the route list message parser: clock, reset, byte stimulus,
// result-side back-pressure and the verdict.
// Depends on rlmp_pkg, route_list_message_parser_top and route_list_result_checker.
module route_list_message_parser_top_test;
  import rlmp_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;  // long receiver hold-off
  localparam int unsigned HOLD_OFF_AFTER  = 400;  // bytes accepted before it
  localparam int unsigned DRAIN_CYCLES    = 20;   // extra wait for stray results
  localparam longint      TIMEOUT_NS      = 10_000_000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rlmp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rlmp_out_t out_data;

  int unsigned error_count;
  int unsigned results_outstanding;
  int unsigned items_sent = 0;

  // Whole input stream, built up front; one entry per item.
  rlmp_in_t    byte_stream[$];
  // Bytes of the message under construction.
  logic [7:0]  message_bytes[$];

  route_list_message_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  route_list_result_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data            (out_data),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset low from the start, then release it for good.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Random byte, biased now and then towards all zeros or all ones.
  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Append a route record: type, prefix, then the given number of address bytes.
  task automatic add_record(input logic v6, input int unsigned addr_bytes);
    message_bytes.push_back(v6 ? TYPE_V6 : TYPE_V4);
    message_bytes.push_back(rand_byte());
    repeat (addr_bytes) message_bytes.push_back(rand_byte());
  endtask

  // Move the message under construction onto the stream, end mark on its last byte.
  task automatic emit_message();
    rlmp_in_t it;
    for (int i = 0; i < message_bytes.size(); i++) begin
      it.data_byte      = message_bytes[i];
      it.end_of_message = (i == message_bytes.size() - 1);
      byte_stream.push_back(it);
    end
    message_bytes.delete();
  endtask

  // Build the stimulus: a short directed prologue, then random messages.
  initial begin
    int unsigned pick, records, cut;
    logic        v6;
    logic [7:0]  t;

    // Short header after a single byte.
    message_bytes.push_back(8'h80);
    emit_message();
    // All-ones version, an IPv4 route, then one stray byte: trailing bytes win
    // even though the type byte is not a known type.
    repeat (4) message_bytes.push_back(8'hFF);
    add_record(1'b0, V4_BYTES);
    message_bytes.push_back(8'h05);
    emit_message();
    // Unknown type whose third byte already carries the end mark.
    repeat (4) message_bytes.push_back(8'h00);
    message_bytes.push_back(8'h07);
    message_bytes.push_back(8'h00);
    message_bytes.push_back(8'hA5);
    emit_message();
    // Clean end straight after the version word.
    message_bytes.push_back(8'h00);
    message_bytes.push_back(8'h00);
    message_bytes.push_back(8'h00);
    message_bytes.push_back(8'h01);
    emit_message();

    // Random part: mostly well-formed messages with random content, the rest
    // broken on purpose or pure noise.
    while (byte_stream.size() < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) begin
        repeat ($urandom_range(1, 24)) message_bytes.push_back(rand_byte());
      end else if (pick >= 86) begin
        repeat ($urandom_range(1, 3)) message_bytes.push_back(rand_byte());
      end else begin
        repeat (4) message_bytes.push_back(rand_byte());
        records = (pick < 60) ? $urandom_range(0, 5) : $urandom_range(0, 2);
        repeat (records) begin
          v6 = 1'($urandom_range(0, 1));
          add_record(v6, v6 ? V6_BYTES : V4_BYTES);
        end
        if (pick >= 78) begin
          // Unknown type: steer clear of the two known codes, keep the rest.
          t = rand_byte();
          if (t == TYPE_V4 || t == TYPE_V6) t = t ^ 8'h80;
          message_bytes.push_back(t);
          message_bytes.push_back(rand_byte());
          repeat ($urandom_range(1, 8)) message_bytes.push_back(rand_byte());
        end else if (pick >= 70) begin
          // Cut one or two bytes into a record.
          repeat ($urandom_range(1, 2)) message_bytes.push_back(rand_byte());
        end else if (pick >= 60) begin
          // Cut inside the address of a known record.
          v6  = 1'($urandom_range(0, 1));
          cut = $urandom_range(1, (v6 ? V6_BYTES : V4_BYTES) - 1);
          add_record(v6, cut);
        end
      end
      emit_message();
    end
  end

  // Sender: offer each byte in turn, idling now and then, and hold the byte
  // until the parser takes it.
  initial begin
    int unsigned idx, gap, r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (idx = 0; idx < byte_stream.size(); idx++) begin
      r = $urandom_range(0, 99);
      if ((idx / 128) % 4 == 1) gap = 0;          // stretch with no idling
      else if (r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= byte_stream[idx];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      items_sent++;
    end
    in_valid <= 1'b0;

    // Let the checker count the results of the last byte, then wait for every
    // predicted result and a little longer for strays.
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: stall in segments of random character, and once hold off for a
  // long stretch while bytes keep coming so the parser backs up into its input.
  initial begin
    int unsigned mode, span;
    logic        held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && items_sent >= HOLD_OFF_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 9);
      span = (mode == 9) ? $urandom_range(20, 60) : $urandom_range(1, 40);
      repeat (span) begin
        if (mode < 3) out_stall <= 1'b0;                        // free flow
        else if (mode < 9) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= 1'b1;                                 // long stall
        @(posedge clk);
      end
    end
  end

  // Give up on a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
sv/rlmp_pkg.sv
sv/rlmp_parse.sv
sv/rlmp_outq.sv
sv/route_list_message_parser_top.sv
tb/sv/route_list_result_checker.sv
tb/sv/route_list_message_parser_top_test.sv
